// ===== src/tsac_pkg.sv =====
// Shared types and constants for the touch sample averager and calibrator.
// Used by every module of the block; depends on nothing.
package tsac_pkg;

   localparam int COORD_W = 12;   // width of one x or y coordinate
   localparam int Z_W     = 8;    // width of one pressure sample
   localparam int BYTE_W  = 8;
   localparam int NIB_W   = 4;
   localparam int FRAC_W  = 16;   // fractional bits of the calibration terms
   localparam int POS_W   = 32;
   localparam int DIV_W   = 32;   // operand width of the shared divider
   localparam int NUM_W   = 34;   // width that holds (avg << 16) - offset without loss
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_X      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_Y     = 3'd4;

   localparam logic MODE_FULL   = 1'b0;   // four bytes x, y, z
   localparam logic MODE_PACKED = 1'b1;   // three bytes x, y

   localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== src/touch_sample_average_calibrate_top.sv =====
// Touch sample averager and calibrator, top level.
// Holds the configuration registers; instantiates tsac_accum, tsac_seq and tsac_div; uses tsac_pkg.
//
// Usage:
//   req_*  : one FIFO byte per transfer; req_tlast marks the final byte of a batch.
//   rsp_*  : one result per batch: averaged (and calibrated) x and y, pressure,
//            sample count in tdata, overflow flag in tuser.
//   csr_*  : register writes, index 0 sample mode, 1/2 x offset and ratio,
//            3/4 y offset and ratio. Always ready; write only between batches.
// Flow: a byte without tlast is taken whenever the block is idle. The tlast byte starts
//   five divisions on one shared 32-step divider (x, y, z averages, then x and y
//   calibration); a division is skipped for an empty batch or a zero ratio.
//   req_tready stays low after a tlast transfer until the result is moved to the
//   output register, and rsp_tvalid rises at the edge where req_tready returns high.
// Reset: registers clear to zero, partial sample and sums clear, no result pending.
// Stall: the result waits in the output register while bytes of the next batch
//   are taken; the next tlast byte keeps req_tready low until the register is free.
module touch_sample_average_calibrate_top #(
   parameter int MAX_SAMPLES = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] fifo_byte
   input  logic                           req_tlast,   // batch_end
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [79:0]                    rsp_tdata,   // [31:0] pos_x, [63:32] pos_y,
                                                       // [71:64] pressure, [79:72] samples_used
   output logic                           rsp_tuser,   // overflowed
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tsac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);

   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SXW = tsac_pkg::COORD_W + CW;
   localparam int SZW = tsac_pkg::Z_W + CW;

   logic                        sample_mode_ff;
   logic [tsac_pkg::POS_W-1:0]  bias_x_ff;
   logic [tsac_pkg::POS_W-1:0]  ratio_x_ff;
   logic [tsac_pkg::POS_W-1:0]  bias_y_ff;
   logic [tsac_pkg::POS_W-1:0]  ratio_y_ff;

   logic                        take;
   logic                        seq_idle;
   logic [SXW-1:0]              batch_sum_x;
   logic [SXW-1:0]              batch_sum_y;
   logic [SZW-1:0]              batch_sum_z;
   logic [CW-1:0]               batch_count;
   logic                        batch_drop;
   tsac_pkg::div_req_type       div_req;
   tsac_pkg::div_rsp_type       div_rsp;
   logic [tsac_pkg::POS_W-1:0]  pos_x;
   logic [tsac_pkg::POS_W-1:0]  pos_y;
   logic [tsac_pkg::Z_W-1:0]    pressure;
   logic [tsac_pkg::BYTE_W-1:0] samples_used;

   assign csr_ready  = 1'b1;
   assign req_tready = seq_idle;
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_mode_ff <= tsac_pkg::MODE_FULL;
         bias_x_ff      <= '0;
         ratio_x_ff     <= '0;
         bias_y_ff      <= '0;
         ratio_y_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tsac_pkg::CSR_SAMPLE_MODE: sample_mode_ff <= csr_data[0];
            tsac_pkg::CSR_BIAS_X:      bias_x_ff      <= csr_data;
            tsac_pkg::CSR_RATIO_X:     ratio_x_ff     <= csr_data;
            tsac_pkg::CSR_BIAS_Y:      bias_y_ff      <= csr_data;
            tsac_pkg::CSR_RATIO_Y:     ratio_y_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   tsac_accum #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .fifo_byte   (req_tdata),
      .batch_end   (req_tlast),
      .sample_mode (sample_mode_ff),
      .batch_sum_x (batch_sum_x),
      .batch_sum_y (batch_sum_y),
      .batch_sum_z (batch_sum_z),
      .batch_count (batch_count),
      .batch_drop  (batch_drop)
   );

   tsac_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tsac_seq #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (take && req_tlast),
      .batch_sum_x      (batch_sum_x),
      .batch_sum_y      (batch_sum_y),
      .batch_sum_z      (batch_sum_z),
      .batch_count      (batch_count),
      .batch_drop       (batch_drop),
      .bias_x           (bias_x_ff),
      .ratio_x          (ratio_x_ff),
      .bias_y           (bias_y_ff),
      .ratio_y          (ratio_y_ff),
      .idle             (seq_idle),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_pos_x        (pos_x),
      .rsp_pos_y        (pos_y),
      .rsp_pressure     (pressure),
      .rsp_samples_used (samples_used),
      .rsp_overflowed   (rsp_tuser)
   );

   assign rsp_tdata = {samples_used, pressure, pos_y, pos_x};

endmodule

// ===== src/tsac_div.sv =====
// Shared unsigned restoring divider, one quotient bit per cycle.
// Uses tsac_pkg for the operand width and the request/response structs.
module tsac_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tsac_pkg::div_req_type div_req,
   output tsac_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(tsac_pkg::DIV_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tsac_pkg::DIV_W - 1);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            step_ff;
   logic [tsac_pkg::DIV_W-1:0]  rem_ff;
   logic [tsac_pkg::DIV_W-1:0]  quo_ff;
   logic [tsac_pkg::DIV_W-1:0]  dsr_ff;

   logic [tsac_pkg::DIV_W:0]    trial;
   logic [tsac_pkg::DIV_W:0]    diff;
   logic                        take_bit;
   logic [tsac_pkg::DIV_W-1:0]  rem_in;

   always_comb begin
      trial    = {rem_ff, quo_ff[tsac_pkg::DIV_W-1]};
      diff     = trial - {1'b0, dsr_ff};
      take_bit = ~diff[tsac_pkg::DIV_W];
      rem_in   = take_bit ? diff[tsac_pkg::DIV_W-1:0] : trial[tsac_pkg::DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !div_req.start && busy_ff && (step_ff == LAST_STEP);
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[tsac_pkg::DIV_W-2:0], take_bit};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== src/tsac_accum.sv =====
// Byte unpacker and running sums of x, y and z with the sample count.
// Uses tsac_pkg for field widths and mode codes.
module tsac_accum #(
   parameter int MAX_SAMPLES = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic [tsac_pkg::BYTE_W-1:0]      fifo_byte,
   input  logic                             batch_end,
   input  logic                             sample_mode,
   output logic [tsac_pkg::COORD_W+$clog2(MAX_SAMPLES+1)-1:0] batch_sum_x,
   output logic [tsac_pkg::COORD_W+$clog2(MAX_SAMPLES+1)-1:0] batch_sum_y,
   output logic [tsac_pkg::Z_W+$clog2(MAX_SAMPLES+1)-1:0]     batch_sum_z,
   output logic [$clog2(MAX_SAMPLES+1)-1:0]                   batch_count,
   output logic                                               batch_drop
);

   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SXW = tsac_pkg::COORD_W + CW;
   localparam int SZW = tsac_pkg::Z_W + CW;
   localparam logic [CW-1:0] CAPACITY = CW'(MAX_SAMPLES);

   localparam logic [1:0] PHASE_HIGH = 2'd0;
   localparam logic [1:0] PHASE_MID  = 2'd1;
   localparam logic [1:0] LAST_FULL   = 2'd3;
   localparam logic [1:0] LAST_PACKED = 2'd2;

   logic [1:0]                  phase_ff;
   logic [tsac_pkg::BYTE_W-1:0] high_ff;
   logic [tsac_pkg::BYTE_W-1:0] mid_ff;
   logic [tsac_pkg::BYTE_W-1:0] low_ff;
   logic [SXW-1:0]              sum_x_ff;
   logic [SXW-1:0]              sum_y_ff;
   logic [SZW-1:0]              sum_z_ff;
   logic [CW-1:0]               count_ff;
   logic                        drop_ff;

   logic                        complete;
   logic                        room;
   logic [tsac_pkg::COORD_W-1:0] x_val;
   logic [tsac_pkg::COORD_W-1:0] y_val;
   logic [tsac_pkg::Z_W-1:0]    z_val;
   logic [tsac_pkg::BYTE_W-1:0] y_low;
   logic [SXW-1:0]              sum_x_in;
   logic [SXW-1:0]              sum_y_in;
   logic [SZW-1:0]              sum_z_in;
   logic [CW-1:0]               count_in;
   logic                        drop_in;

   always_comb begin
      complete = phase_ff >= ((sample_mode == tsac_pkg::MODE_PACKED) ? LAST_PACKED : LAST_FULL);
      room     = count_ff < CAPACITY;
      y_low    = (sample_mode == tsac_pkg::MODE_PACKED) ? fifo_byte : low_ff;
      x_val    = {high_ff, mid_ff[tsac_pkg::BYTE_W-1:tsac_pkg::NIB_W]};
      y_val    = {mid_ff[tsac_pkg::NIB_W-1:0], y_low};
      z_val    = (sample_mode == tsac_pkg::MODE_PACKED) ? tsac_pkg::Z_W'(1) : fifo_byte;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      sum_z_in = sum_z_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      if (complete) begin
         if (room) begin
            sum_x_in = sum_x_ff + SXW'(x_val);
            sum_y_in = sum_y_ff + SXW'(y_val);
            sum_z_in = sum_z_ff + SZW'(z_val);
            count_in = count_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   // batch totals including the byte now offered
   assign batch_sum_x = sum_x_in;
   assign batch_sum_y = sum_y_in;
   assign batch_sum_z = sum_z_in;
   assign batch_count = count_in;
   assign batch_drop  = drop_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HIGH;
         high_ff  <= '0;
         mid_ff   <= '0;
         low_ff   <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (take) begin
         if (batch_end || complete) begin
            phase_ff <= PHASE_HIGH;
         end else begin
            phase_ff <= phase_ff + 1'b1;
         end
         if (!complete) begin
            case (phase_ff)
               PHASE_HIGH: high_ff <= fifo_byte;
               PHASE_MID:  mid_ff  <= fifo_byte;
               default:    low_ff  <= fifo_byte;
            endcase
         end
         // clear the batch once its totals are handed over
         sum_x_ff <= batch_end ? '0 : sum_x_in;
         sum_y_ff <= batch_end ? '0 : sum_y_in;
         sum_z_ff <= batch_end ? '0 : sum_z_in;
         count_ff <= batch_end ? '0 : count_in;
         drop_ff  <= batch_end ? 1'b0 : drop_in;
      end
   end

endmodule

// ===== src/tsac_seq.sv =====
// Sequencer: averages and calibration through the shared divider, result register.
// Uses tsac_pkg for widths, saturation bounds and the divider structs.
module tsac_seq #(
   parameter int MAX_SAMPLES = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tsac_pkg::COORD_W+$clog2(MAX_SAMPLES+1)-1:0] batch_sum_x,
   input  logic [tsac_pkg::COORD_W+$clog2(MAX_SAMPLES+1)-1:0] batch_sum_y,
   input  logic [tsac_pkg::Z_W+$clog2(MAX_SAMPLES+1)-1:0]     batch_sum_z,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]                   batch_count,
   input  logic                              batch_drop,
   input  logic [tsac_pkg::POS_W-1:0]        bias_x,
   input  logic [tsac_pkg::POS_W-1:0]        ratio_x,
   input  logic [tsac_pkg::POS_W-1:0]        bias_y,
   input  logic [tsac_pkg::POS_W-1:0]        ratio_y,
   output logic                              idle,
   output tsac_pkg::div_req_type             div_req,
   input  tsac_pkg::div_rsp_type             div_rsp,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tsac_pkg::POS_W-1:0]        rsp_pos_x,
   output logic [tsac_pkg::POS_W-1:0]        rsp_pos_y,
   output logic [tsac_pkg::Z_W-1:0]          rsp_pressure,
   output logic [tsac_pkg::BYTE_W-1:0]       rsp_samples_used,
   output logic                              rsp_overflowed
);

   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int SXW = tsac_pkg::COORD_W + CW;
   localparam int SZW = tsac_pkg::Z_W + CW;
   localparam int DW  = tsac_pkg::DIV_W;
   localparam int PW  = tsac_pkg::POS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_RUN,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_AVG_X,
      OP_AVG_Y,
      OP_AVG_Z,
      OP_CAL_X,
      OP_CAL_Y
   } op_type;

   state_type                 state_ff;
   op_type                    op_ff;
   op_type                    op_in;
   logic [SXW-1:0]            sum_x_ff;
   logic [SXW-1:0]            sum_y_ff;
   logic [SZW-1:0]            sum_z_ff;
   logic [CW-1:0]             count_ff;
   logic                      drop_ff;
   logic [tsac_pkg::COORD_W-1:0] avg_x_ff;
   logic [tsac_pkg::COORD_W-1:0] avg_y_ff;
   logic [tsac_pkg::Z_W-1:0]  avg_z_ff;
   logic [PW-1:0]             pos_x_ff;
   logic [PW-1:0]             pos_y_ff;
   logic                      rsp_valid_ff;
   logic [PW-1:0]             rsp_pos_x_ff;
   logic [PW-1:0]             rsp_pos_y_ff;
   logic [tsac_pkg::Z_W-1:0]  rsp_pressure_ff;
   logic [tsac_pkg::BYTE_W-1:0] rsp_samples_ff;
   logic                      rsp_drop_ff;

   logic                      is_cal;
   logic                      skip;
   logic [tsac_pkg::COORD_W-1:0] cal_avg;
   logic [PW-1:0]             cal_offset;
   logic [PW-1:0]             cal_ratio;
   logic [tsac_pkg::NUM_W-1:0] num;
   logic [tsac_pkg::NUM_W-1:0] num_abs;
   logic                      num_neg;
   logic                      ratio_neg;
   logic [DW-1:0]             ratio_abs;
   logic                      quo_neg;
   logic [DW-1:0]             quo;
   logic [PW-1:0]             cal_res;
   logic [DW-1:0]             res_val;
   logic [tsac_pkg::BYTE_W+CW-1:0] count_wide;

   always_comb begin
      is_cal     = (op_ff == OP_CAL_X) || (op_ff == OP_CAL_Y);
      cal_avg    = (op_ff == OP_CAL_X) ? avg_x_ff : avg_y_ff;
      cal_offset = (op_ff == OP_CAL_X) ? bias_x : bias_y;
      cal_ratio  = (op_ff == OP_CAL_X) ? ratio_x  : ratio_y;

      // (avg << 16) - offset, formed exactly
      num = {{(tsac_pkg::NUM_W - tsac_pkg::COORD_W - tsac_pkg::FRAC_W){1'b0}},
             cal_avg, {tsac_pkg::FRAC_W{1'b0}}}
            - {{(tsac_pkg::NUM_W - PW){cal_offset[PW-1]}}, cal_offset};
      num_neg   = num[tsac_pkg::NUM_W-1];
      num_abs   = num_neg ? (~num + 1'b1) : num;
      ratio_neg = cal_ratio[PW-1];
      ratio_abs = ratio_neg ? (~cal_ratio + 1'b1) : cal_ratio;
      quo_neg   = num_neg ^ ratio_neg;
      quo       = div_rsp.quotient;

      // truncate toward zero, then saturate to the signed 32-bit range
      if (!quo_neg) begin
         cal_res = quo[DW-1] ? tsac_pkg::POS_MAX : quo;
      end else if (quo > tsac_pkg::POS_MIN) begin
         cal_res = tsac_pkg::POS_MIN;
      end else begin
         cal_res = ~quo + 1'b1;
      end

      skip = is_cal ? (cal_ratio == '0) : (count_ff == '0);

      div_req.start = (state_ff == ST_LAUNCH) && !skip;
      case (op_ff)
         OP_AVG_X: begin
            div_req.dividend = {{(DW - SXW){1'b0}}, sum_x_ff};
            div_req.divisor  = {{(DW - CW){1'b0}}, count_ff};
         end
         OP_AVG_Y: begin
            div_req.dividend = {{(DW - SXW){1'b0}}, sum_y_ff};
            div_req.divisor  = {{(DW - CW){1'b0}}, count_ff};
         end
         OP_AVG_Z: begin
            div_req.dividend = {{(DW - SZW){1'b0}}, sum_z_ff};
            div_req.divisor  = {{(DW - CW){1'b0}}, count_ff};
         end
         default: begin
            div_req.dividend = num_abs[DW-1:0];
            div_req.divisor  = ratio_abs;
         end
      endcase

      if (state_ff == ST_LAUNCH) begin
         // empty batch averages to zero; zero ratio passes the average through
         res_val = is_cal ? {{(DW - tsac_pkg::COORD_W){1'b0}}, cal_avg} : '0;
      end else begin
         res_val = is_cal ? cal_res : quo;
      end

      case (op_ff)
         OP_AVG_X: op_in = OP_AVG_Y;
         OP_AVG_Y: op_in = OP_AVG_Z;
         OP_AVG_Z: op_in = OP_CAL_X;
         OP_CAL_X: op_in = OP_CAL_Y;
         default:  op_in = OP_AVG_X;
      endcase

      count_wide = {{tsac_pkg::BYTE_W{1'b0}}, count_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_AVG_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= OP_AVG_X;
                  state_ff <= ST_LAUNCH;
               end
            end
            ST_LAUNCH: begin
               if (skip) begin
                  op_ff    <= op_in;
                  state_ff <= (op_ff == OP_CAL_Y) ? ST_EMIT : ST_LAUNCH;
               end else begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (div_rsp.done) begin
                  op_ff    <= op_in;
                  state_ff <= (op_ff == OP_CAL_Y) ? ST_EMIT : ST_LAUNCH;
               end
            end
            ST_EMIT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // batch capture, intermediate results and the result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         sum_x_ff <= batch_sum_x;
         sum_y_ff <= batch_sum_y;
         sum_z_ff <= batch_sum_z;
         count_ff <= batch_count;
         drop_ff  <= batch_drop;
      end
      if ((state_ff == ST_LAUNCH && skip) || (state_ff == ST_RUN && div_rsp.done)) begin
         case (op_ff)
            OP_AVG_X: avg_x_ff <= res_val[tsac_pkg::COORD_W-1:0];
            OP_AVG_Y: avg_y_ff <= res_val[tsac_pkg::COORD_W-1:0];
            OP_AVG_Z: avg_z_ff <= res_val[tsac_pkg::Z_W-1:0];
            OP_CAL_X: pos_x_ff <= res_val;
            default:  pos_y_ff <= res_val;
         endcase
      end
      if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_pos_x_ff    <= pos_x_ff;
         rsp_pos_y_ff    <= pos_y_ff;
         rsp_pressure_ff <= avg_z_ff;
         rsp_samples_ff  <= count_wide[tsac_pkg::BYTE_W-1:0];
         rsp_drop_ff     <= drop_ff;
      end
   end

   assign idle             = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_pressure     = rsp_pressure_ff;
   assign rsp_samples_used = rsp_samples_ff;
   assign rsp_overflowed   = rsp_drop_ff;

endmodule

// ===== bench/tb_touch_sample_average_calibrate_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for touch_sample_average_calibrate_top: FIFO bytes in, batch results out.
// Keeps its own model of sample sums, averages and calibration; needs tsac_pkg and the RTL only.
module tb_touch_sample_average_calibrate_top;

   localparam int MAX_SAMPLES   = 128;
   localparam int HOLD_CYCLES   = 500;
   localparam int SETTLE_CYCLES = 16;
   localparam int END_CYCLES    = 200;
   localparam int PHASES        = 10;
   localparam int PHASE_BYTES   = 80;
   localparam longint Q_MAX     = 64'sd2147483647;
   localparam longint Q_MIN     = -64'sd2147483648;

   // indexes outside the register map; writes to them must change nothing
   localparam logic [tsac_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [tsac_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [7:0] fifo_byte;
      logic       batch_end;
   } fifo_item_type;

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [7:0]  pressure;
      logic [7:0]  samples_used;
      logic        overflowed;
   } touch_result_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata  = '0;   // [7:0] fifo_byte
   logic                           req_tlast  = 1'b0; // batch_end
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [79:0]                    rsp_tdata;         // [31:0] pos_x, [63:32] pos_y,
                                                      // [71:64] pressure, [79:72] samples_used
   logic                           rsp_tuser;         // overflowed
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [tsac_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]                    csr_data   = '0;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic pressure_armed = 1'b0;
   int   hold_left      = 0;

   // configuration as the block should hold it
   logic               cfg_mode    = tsac_pkg::MODE_FULL;
   logic signed [31:0] cfg_off_x   = '0;
   logic signed [31:0] cfg_ratio_x = '0;
   logic signed [31:0] cfg_off_y   = '0;
   logic signed [31:0] cfg_ratio_y = '0;

   // batch state as the block should hold it
   logic [1:0]  phase_cnt = '0;
   logic [7:0]  hold_hi   = '0;
   logic [7:0]  hold_mid  = '0;
   logic [7:0]  hold_lo   = '0;
   logic [18:0] acc_x     = '0;
   logic [18:0] acc_y     = '0;
   logic [14:0] acc_z     = '0;
   logic [7:0]  acc_n     = '0;
   logic        dropped   = 1'b0;

   fifo_item_type    pending_bytes[$];
   touch_result_type expected_results[$];
   fifo_item_type    next_byte;

   int bytes_taken     = 0;
   int results_checked = 0;
   int drop_results    = 0;
   int fail_count      = 0;

   touch_sample_average_calibrate_top #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [31:0] calibrate_axis(logic [18:0] avg, logic signed [31:0] offset,
                                                  logic signed [31:0] ratio);
      longint num;
      longint q;
      if (ratio == 0) return 32'(avg);
      num = longint'(avg) * 65536 - longint'(offset);
      q = num / longint'(ratio);
      if (q > Q_MAX) q = Q_MAX;
      if (q < Q_MIN) q = Q_MIN;
      return q[31:0];
   endfunction

   // Advance the batch model by one accepted byte; queue a result on a batch end.
   task automatic take_fifo_byte(fifo_item_type it);
      logic [1:0]       last_idx;
      logic [11:0]      sx;
      logic [11:0]      sy;
      logic [7:0]       sz;
      logic [7:0]       ylow;
      logic [18:0]      avg_x;
      logic [18:0]      avg_y;
      logic [14:0]      avg_z;
      touch_result_type r;
      last_idx = (cfg_mode == tsac_pkg::MODE_PACKED) ? 2'd2 : 2'd3;
      bytes_taken++;
      if (phase_cnt >= last_idx) begin
         // in packed mode the current byte is the low y byte, z counts samples
         ylow = (cfg_mode == tsac_pkg::MODE_PACKED) ? it.fifo_byte : hold_lo;
         sz   = (cfg_mode == tsac_pkg::MODE_PACKED) ? 8'd1 : it.fifo_byte;
         sx   = {hold_hi, hold_mid[7:4]};
         sy   = {hold_mid[3:0], ylow};
         if (acc_n < MAX_SAMPLES) begin
            acc_x += sx;
            acc_y += sy;
            acc_z += sz;
            acc_n++;
         end else begin
            dropped = 1'b1;
         end
         phase_cnt = '0;
      end else begin
         if (phase_cnt == 2'd0) hold_hi = it.fifo_byte;
         else if (phase_cnt == 2'd1) hold_mid = it.fifo_byte;
         else hold_lo = it.fifo_byte;
         phase_cnt++;
      end
      if (it.batch_end) begin
         avg_x = '0;
         avg_y = '0;
         avg_z = '0;
         if (acc_n != 0) begin
            avg_x = acc_x / acc_n;
            avg_y = acc_y / acc_n;
            avg_z = acc_z / acc_n;
         end
         r.pos_x        = calibrate_axis(avg_x, cfg_off_x, cfg_ratio_x);
         r.pos_y        = calibrate_axis(avg_y, cfg_off_y, cfg_ratio_y);
         r.pressure     = avg_z[7:0];
         r.samples_used = acc_n;
         r.overflowed   = dropped;
         expected_results.push_back(r);
         phase_cnt = '0;
         acc_x     = '0;
         acc_y     = '0;
         acc_z     = '0;
         acc_n     = '0;
         dropped   = 1'b0;
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      fail_count++;
      if (fail_count <= 40)
         $display("MISMATCH at %0t, result %0d, %s: got 0x%0h, expected 0x%0h",
                  $time, results_checked, what, got, want);
   endtask

   task automatic check_result(logic [79:0] data, logic flag);
      touch_result_type want;
      results_checked++;
      if (flag) drop_results++;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing outstanding", data[31:0], '0);
         return;
      end
      want = expected_results.pop_front();
      if (data[31:0] !== want.pos_x) report_mismatch("pos_x", data[31:0], want.pos_x);
      if (data[63:32] !== want.pos_y) report_mismatch("pos_y", data[63:32], want.pos_y);
      if (data[71:64] !== want.pressure)
         report_mismatch("pressure", 32'(data[71:64]), 32'(want.pressure));
      if (data[79:72] !== want.samples_used)
         report_mismatch("samples_used", 32'(data[79:72]), 32'(want.samples_used));
      if (flag !== want.overflowed)
         report_mismatch("overflowed", 32'(flag), 32'(want.overflowed));
   endtask

   // byte driver: offer the next pending byte whenever the slot is free
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) take_fifo_byte({req_tdata, req_tlast});
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_byte = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.fifo_byte;
               req_tlast  <= next_byte.batch_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tuser);
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long hold-off after each transfer while armed, so the next result backs up into the input
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      else if (pressure_armed && rsp_tvalid && rsp_tready) hold_left <= HOLD_CYCLES;
   end

   function automatic logic [11:0] pick_coord();
      case ($urandom_range(7))
         0: return 12'h000;
         1: return 12'hFFF;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] typical_offset();
      return 32'($urandom_range(0, 32'h1FFF_FFFF)) - 32'h1000_0000;
   endfunction

   function automatic logic [31:0] typical_ratio();
      logic [31:0] r;
      r = $urandom_range(32'h100, 32'h4_0000);
      return ($urandom_range(1) != 0) ? -r : r;
   endfunction

   task automatic push_byte(logic [7:0] b, logic last);
      pending_bytes.push_back({b, last});
   endtask

   task automatic queue_batch(int n_samples, logic fmt);
      fifo_item_type batch[$];
      logic [11:0]   sx;
      logic [11:0]   sy;
      for (int s = 0; s < n_samples; s++) begin
         sx = pick_coord();
         sy = pick_coord();
         batch.push_back({sx[11:4], 1'b0});
         batch.push_back({sx[3:0], sy[11:8], 1'b0});
         batch.push_back({sy[7:0], 1'b0});
         if (fmt == tsac_pkg::MODE_FULL) batch.push_back({8'($urandom), 1'b0});
      end
      if (batch.size() == 0) batch.push_back({8'($urandom), 1'b0});
      // now and then end the batch inside its last sample
      if (batch.size() > 2 && $urandom_range(9) == 0)
         repeat ($urandom_range(1, 2)) void'(batch.pop_back());
      batch[batch.size()-1].batch_end = 1'b1;
      foreach (batch[i]) pending_bytes.push_back(batch[i]);
   endtask

   task automatic write_reg(logic [tsac_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         tsac_pkg::CSR_SAMPLE_MODE: cfg_mode    = value[0];
         tsac_pkg::CSR_BIAS_X:      cfg_off_x   = value;
         tsac_pkg::CSR_RATIO_X:     cfg_ratio_x = value;
         tsac_pkg::CSR_BIAS_Y:      cfg_off_y   = value;
         tsac_pkg::CSR_RATIO_Y:     cfg_ratio_y = value;
         default: ;
      endcase
   endtask

   // hold until every byte is taken and every result is back, then let the block settle
   task automatic wait_idle(int settle);
      while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      logic        mode;
      logic [31:0] ox;
      logic [31:0] rx;
      logic [31:0] oy;
      logic [31:0] ry;
      logic [31:0] word;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset configuration, full mode, no calibration
      @(negedge clock);
      push_byte(8'hFF, 1'b1);                       // empty batch, lone partial byte
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
      push_byte(8'hAB, 1'b0); push_byte(8'hCD, 1'b0);
      push_byte(8'hEF, 1'b0); push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0); push_byte(8'h56, 1'b0);
      push_byte(8'h78, 1'b0); push_byte(8'h9A, 1'b1);
      push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
      push_byte(8'h56, 1'b0); push_byte(8'h78, 1'b0);
      push_byte(8'h9A, 1'b0); push_byte(8'hBC, 1'b1); // batch ends inside second sample
      wait_idle(SETTLE_CYCLES);

      // directed: calibration driven into both saturation bounds
      write_reg(tsac_pkg::CSR_BIAS_X, 32'h8000_0000);
      write_reg(tsac_pkg::CSR_RATIO_X, 32'h0000_0001);
      write_reg(tsac_pkg::CSR_BIAS_Y, 32'h8000_0000);
      write_reg(tsac_pkg::CSR_RATIO_Y, 32'hFFFF_FFFF);
      @(negedge clock);
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
      wait_idle(SETTLE_CYCLES);

      for (int p = 0; p < PHASES; p++) begin
         mode = (p % 2 == 0) ? tsac_pkg::MODE_FULL : tsac_pkg::MODE_PACKED;
         case (p)
            0: begin ox = $urandom; rx = '0; oy = $urandom; ry = '0; end
            1: begin ox = '0; rx = 32'h0001_0000; oy = '0; ry = 32'h0001_0000; end
            3: begin
               ox = 32'h7FFF_FFFF; rx = 32'h8000_0000;
               oy = 32'h8000_0000; ry = 32'h7FFF_FFFF;
            end
            4: begin ox = $urandom; rx = 32'h1; oy = $urandom; ry = 32'hFFFF_FFFF; end
            6: begin ox = $urandom; rx = $urandom; oy = $urandom; ry = $urandom; end
            8: begin ox = 32'h8000_0000; rx = '0; oy = 32'h7FFF_FFFF; ry = typical_ratio(); end
            default: begin
               ox = typical_offset(); rx = typical_ratio();
               oy = typical_offset(); ry = typical_ratio();
            end
         endcase
         word = $urandom;
         word[0] = mode;
         write_reg(tsac_pkg::CSR_SAMPLE_MODE, word);
         write_reg(tsac_pkg::CSR_BIAS_X, ox);
         write_reg(tsac_pkg::CSR_RATIO_X, rx);
         write_reg(tsac_pkg::CSR_BIAS_Y, oy);
         write_reg(tsac_pkg::CSR_RATIO_Y, ry);
         if (p == 6) begin
            write_reg(CSR_UNUSED_LO, $urandom);
            write_reg(CSR_UNUSED_HI, $urandom);
         end

         case (p % 4)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 77; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 77; end
            default: begin send_idle_pct <= 21; recv_stall_pct <= 21; end
         endcase
         pressure_armed <= (p == 4);

         @(negedge clock);
         while (pending_bytes.size() < PHASE_BYTES) begin
            if ($urandom_range(11) == 0)
               repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'($urandom_range(1)));
            else
               queue_batch(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6), mode);
         end
         if (p == 3) queue_batch($urandom_range(129, 132), mode);
         if (p == 7) queue_batch(130, mode);
         queue_batch(1, mode);
         // leave a partial sample behind; after the first phase it meets a mode change
         repeat ((p == 0) ? 3 : $urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
         wait_idle((p == PHASES - 1) ? END_CYCLES : SETTLE_CYCLES);
      end

      $display("summary: %0d FIFO bytes over %0d register configurations, full and packed modes",
               bytes_taken, PHASES + 2);
      $display("summary: %0d batch results checked, %0d of them with dropped samples",
               results_checked, drop_results);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
